>>> rtl/core/bscl_pkg.sv
`default_nettype none

package bscl_pkg;

  // Fixed widths of the request / response fields
  localparam int unsigned OP_W      = 2;
  localparam int unsigned ID_W      = 64;
  localparam int unsigned DIST_W    = 32;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned COUNT_W   = 9;
  localparam int unsigned CFG_W     = 9;

  // Defaults for the top level parameters
  localparam int unsigned DEF_MAX_SLOTS = 256;
  localparam int unsigned DEF_ID_BITS   = 64;
  localparam int unsigned DEF_DIST_BITS = 32;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(200);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_VISIT  = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE           = 3'd0,
    ST_DUPLICATE      = 3'd1,
    ST_DROPPED        = 3'd2,
    ST_NONE_UNVISITED = 3'd3,
    ST_EMPTY_POS      = 3'd4
  } status_e;

  typedef struct packed {
    op_e                operation;
    logic [ID_W-1:0]    node_id;
    logic [DIST_W-1:0]  node_distance;
    logic [POS_W-1:0]   read_position;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]    entry_id;
    logic [DIST_W-1:0]  entry_distance;
    logic               entry_was_visited;
    status_e            status;
    logic [COUNT_W-1:0] list_count;
    logic [COUNT_W-1:0] unvisited_count;
  } rsp_t;

  // Strobes toward the entry store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/bscl_store.sv
`default_nettype none

module bscl_store #(
  parameter int unsigned MAX_SLOTS = 256,
  parameter int unsigned ENT_W     = 97
) (
  input  wire logic                         clk_i,
  input  wire bscl_pkg::mem_ctl_t           ctl_i,
  input  wire logic [$clog2(MAX_SLOTS)-1:0] waddr_i,
  input  wire logic [ENT_W-1:0]             wdata_i,
  input  wire logic [$clog2(MAX_SLOTS)-1:0] raddr_i,
  output logic      [ENT_W-1:0]             rdata_o
);
  import bscl_pkg::*;

  // entry = {visited, distance, id}
  logic [ENT_W-1:0] mem [MAX_SLOTS];
  logic [ENT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/bscl_ctrl.sv
`default_nettype none

module bscl_ctrl #(
  parameter int unsigned MAX_SLOTS = 256,
  parameter int unsigned ID_BITS   = 64,
  parameter int unsigned DIST_BITS = 32,
  localparam int unsigned IDX_W    = $clog2(MAX_SLOTS),
  localparam int unsigned CNT_W    = $clog2(MAX_SLOTS + 1),
  localparam int unsigned ENT_W    = ID_BITS + DIST_BITS + 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire bscl_pkg::req_t     req_i,
  input  wire logic [CNT_W-1:0]   cap_i,
  output logic                    busy_o,
  output bscl_pkg::mem_ctl_t      mem_ctl_o,
  output logic [IDX_W-1:0]        waddr_o,
  output logic [ENT_W-1:0]        wdata_o,
  output logic [IDX_W-1:0]        raddr_o,
  input  wire logic [ENT_W-1:0]   rdata_i,
  output logic                    rsp_valid_o,
  output bscl_pkg::rsp_t          rsp_o
);
  import bscl_pkg::*;

  localparam int unsigned RP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_RDD    = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic [ID_BITS-1:0]   id_q, id_d;
  logic [DIST_BITS-1:0] dist_q, dist_d;
  logic [CNT_W-1:0]     occ_q, occ_d;
  logic [CNT_W-1:0]     pend_q, pend_d;
  logic [CNT_W-1:0]     ptr_q, ptr_d;
  logic [CNT_W-1:0]     pos_q, pos_d;
  logic [IDX_W-1:0]     ra_q, ra_d;
  logic                 rv_q, rv_d;
  logic                 found_q, found_d;
  logic                 lastvis_q, lastvis_d;
  logic                 rsp_v_q, rsp_v_d;
  rsp_t                 rsp_q, rsp_d;

  logic [ID_BITS-1:0]   rd_id;
  logic [DIST_BITS-1:0] rd_dist;
  logic                 rd_vis;
  logic                 id_eq;
  logic                 dist_lt;
  logic                 fin;
  status_e              st;
  logic [ID_BITS-1:0]   out_id;
  logic [DIST_BITS-1:0] out_dist;
  logic                 out_vis;

  assign rd_id   = rdata_i[ID_BITS-1:0];
  assign rd_dist = rdata_i[ID_BITS +: DIST_BITS];
  assign rd_vis  = rdata_i[ENT_W-1];

  // shared compare unit, fed by the store's read port
  assign id_eq   = (rd_id == id_q);
  assign dist_lt = (dist_q < rd_dist);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    id_d      = id_q;
    dist_d    = dist_q;
    occ_d     = occ_q;
    pend_d    = pend_q;
    ptr_d     = ptr_q;
    pos_d     = pos_q;
    ra_d      = ra_q;
    rv_d      = 1'b0;
    found_d   = found_q;
    lastvis_d = lastvis_q;
    mem_ctl_o = '0;
    raddr_o   = ptr_q[IDX_W-1:0];
    waddr_o   = ra_q;
    wdata_o   = rdata_i;
    fin       = 1'b0;
    st        = ST_DONE;
    out_id    = '0;
    out_dist  = '0;
    out_vis   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d      = req_i.operation;
          id_d      = req_i.node_id[ID_BITS-1:0];
          dist_d    = req_i.node_distance[DIST_BITS-1:0];
          ptr_d     = '0;
          found_d   = 1'b0;
          lastvis_d = 1'b0;
          case (req_i.operation)
            OP_CLEAR: begin
              occ_d  = '0;
              pend_d = '0;
              fin    = 1'b1;
            end
            OP_INSERT, OP_VISIT: begin
              state_d = S_SCAN;
            end
            OP_READ: begin
              if (RP_W'(req_i.read_position) < RP_W'(occ_q)) begin
                mem_ctl_o.rd_en = 1'b1;
                raddr_o         = IDX_W'(req_i.read_position);
                state_d         = S_RDD;
              end else begin
                fin = 1'b1;
                st  = ST_EMPTY_POS;
              end
            end
            default: ;
          endcase
        end
      end

      S_RDD: begin
        fin      = 1'b1;
        out_id   = rd_id;
        out_dist = rd_dist;
        out_vis  = rd_vis;
      end

      // walk 0..occ-1, one read per cycle, compare in the next cycle
      S_SCAN: begin
        if (ptr_q < occ_q) begin
          mem_ctl_o.rd_en = 1'b1;
          raddr_o         = ptr_q[IDX_W-1:0];
          ra_d            = ptr_q[IDX_W-1:0];
          rv_d            = 1'b1;
          ptr_d           = ptr_q + 1'b1;
        end
        if (rv_q) begin
          if (op_q == OP_INSERT) begin
            if (id_eq) begin
              fin = 1'b1;
              st  = ST_DUPLICATE;
            end else begin
              if (!found_q && dist_lt) begin
                found_d = 1'b1;
                pos_d   = CNT_W'(ra_q);
              end
              if (CNT_W'(ra_q) == occ_q - 1'b1) begin
                lastvis_d = rd_vis;
              end
            end
          end else if (!rd_vis) begin
            mem_ctl_o.wr_en = 1'b1;
            waddr_o         = ra_q;
            wdata_o         = {1'b1, rd_dist, rd_id};
            if (pend_q != '0) begin
              pend_d = pend_q - 1'b1;
            end
            fin      = 1'b1;
            out_id   = rd_id;
            out_dist = rd_dist;
          end
        end else if (ptr_q >= occ_q) begin
          if (op_q == OP_INSERT) begin
            state_d = S_DECIDE;
          end else begin
            fin = 1'b1;
            st  = ST_NONE_UNVISITED;
          end
        end
      end

      S_DECIDE: begin
        pos_d = found_q ? pos_q : occ_q;
        if (occ_q < cap_i) begin
          ptr_d   = occ_q;
          occ_d   = occ_q + 1'b1;
          pend_d  = pend_q + 1'b1;
          state_d = S_SHIFT;
        end else if (!found_q) begin
          fin = 1'b1;
          st  = ST_DROPPED;
        end else begin
          // last entry falls off; its pending mark goes with it
          ptr_d   = occ_q - 1'b1;
          pend_d  = lastvis_q ? pend_q + 1'b1 : pend_q;
          state_d = S_SHIFT;
        end
      end

      // move entries pos..last-1 up by one, top down; read j, write j+1
      S_SHIFT: begin
        if (ptr_q > pos_q) begin
          mem_ctl_o.rd_en = 1'b1;
          raddr_o         = IDX_W'(ptr_q - 1'b1);
          ra_d            = IDX_W'(ptr_q - 1'b1);
          rv_d            = 1'b1;
          ptr_d           = ptr_q - 1'b1;
        end
        if (rv_q) begin
          mem_ctl_o.wr_en = 1'b1;
          waddr_o         = ra_q + 1'b1;
          wdata_o         = rdata_i;
        end else if (ptr_q <= pos_q) begin
          mem_ctl_o.wr_en = 1'b1;
          waddr_o         = IDX_W'(pos_q);
          wdata_o         = {1'b0, dist_q, id_q};
          fin             = 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      state_d = S_IDLE;
    end

    rsp_v_d                   = fin;
    rsp_d.entry_id            = ID_W'(out_id);
    rsp_d.entry_distance      = DIST_W'(out_dist);
    rsp_d.entry_was_visited   = out_vis;
    rsp_d.status              = st;
    rsp_d.list_count          = COUNT_W'(occ_d);
    rsp_d.unvisited_count     = COUNT_W'(pend_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
      pend_q  <= '0;
      rv_q    <= 1'b0;
      rsp_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      pend_q  <= pend_d;
      rv_q    <= rv_d;
      rsp_v_q <= rsp_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    id_q      <= id_d;
    dist_q    <= dist_d;
    ptr_q     <= ptr_d;
    pos_q     <= pos_d;
    ra_q      <= ra_d;
    found_q   <= found_d;
    lastvis_q <= lastvis_d;
    rsp_q     <= rsp_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_v_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

>>> rtl/core/bounded_sorted_candidate_list.sv
// Sorted candidate list for a greedy nearest-neighbor graph search. Entries
// (id, distance, visited) sit in one single-port-read, single-port-write
// memory in ascending distance order; a small sequencer walks it with one
// shared compare unit. A request is taken when start is high and busy is
// low, and its response shows on rsp_o for exactly one cycle with done_o
// high. The receiver cannot stall: sample rsp_o whenever done_o is high.
// Steps per request type:
//   clear          empties the list without touching the memory
//   read           reads read_position if it is below the count
//   visit          scans up, marks the first unvisited entry visited
//   insert         scan (duplicate check, slot search), decide, then
//                  shift entries up and write the new entry in place
// Run time is set by the memory walk: one entry read per cycle during the
// scan, and one entry moved per cycle while making room for a new entry.
// capacity_limit is taken from the cfg channel (always ready); 0 acts as 1
// and values above MAX_SLOTS act as MAX_SLOTS. Write it only while idle.
// No clearing pass is needed after reset.
`default_nettype none

module bounded_sorted_candidate_list #(
  parameter int unsigned MAX_SLOTS = bscl_pkg::DEF_MAX_SLOTS,
  parameter int unsigned ID_BITS   = bscl_pkg::DEF_ID_BITS,
  parameter int unsigned DIST_BITS = bscl_pkg::DEF_DIST_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire bscl_pkg::req_t                req_i,
  output logic                               done_o,
  output bscl_pkg::rsp_t                     rsp_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bscl_pkg::CFG_W-1:0]    cfg_data_i
);
  import bscl_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned ENT_W = ID_BITS + DIST_BITS + 1;
  localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0] cap_q;
  logic [CMP_W-1:0] cap_wide;
  logic [CNT_W-1:0] cap_eff;
  logic             accept;

  mem_ctl_t         mem_ctl;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;
  logic [ENT_W-1:0] wdata;
  logic [ENT_W-1:0] rdata;

  // capacity register; the channel never pushes back
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  // clamp capacity into 1..MAX_SLOTS
  always_comb begin
    cap_wide = CMP_W'(cap_q);
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_wide > CMP_W'(MAX_SLOTS)) begin
      cap_eff = CNT_W'(MAX_SLOTS);
    end else begin
      cap_eff = CNT_W'(cap_wide);
    end
  end

  assign accept = start && !busy;

  bscl_ctrl #(
    .MAX_SLOTS (MAX_SLOTS),
    .ID_BITS   (ID_BITS),
    .DIST_BITS (DIST_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .req_i       (req_i),
    .cap_i       (cap_eff),
    .busy_o      (busy),
    .mem_ctl_o   (mem_ctl),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .rsp_valid_o (done_o),
    .rsp_o       (rsp_o)
  );

  bscl_store #(
    .MAX_SLOTS (MAX_SLOTS),
    .ENT_W     (ENT_W)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

`default_nettype wire

>>> rtl/core/bscl_checker.sv
`default_nettype none

module bscl_checker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  input  wire logic                       busy,
  input  wire bscl_pkg::req_t             req_i,
  input  wire logic                       done_o,
  input  wire bscl_pkg::rsp_t             rsp_o
);
  import bscl_pkg::*;

  // a response is only shown once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("response while busy");

  // clear answers in the next cycle with an empty list
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.operation == OP_CLEAR) |=>
      (done_o && rsp_o.list_count == '0 && rsp_o.unvisited_count == '0))
    else $error("clear did not empty the list");

  // pending count never exceeds the occupancy in a response
  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.unvisited_count <= rsp_o.list_count))
    else $error("unvisited count above list count");

  // failed visit or read carries no entry
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == ST_NONE_UNVISITED || rsp_o.status == ST_EMPTY_POS))
      |-> (rsp_o.entry_id == '0 && rsp_o.entry_distance == '0 &&
           !rsp_o.entry_was_visited))
    else $error("failed request returned entry data");

endmodule

bind bounded_sorted_candidate_list bscl_checker u_bscl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .req_i       (req_i),
  .done_o      (done_o),
  .rsp_o       (rsp_o)
);

`default_nettype wire
